>>> rtl/sds_pkg.sv
package sds_pkg;

   localparam int CYL_BITS       = 16;
   localparam int DISK_BITS      = 17;
   localparam int TOTAL_BITS     = 22;
   localparam int ORDER_BITS     = 6;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 17;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISK_CYLINDERS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_HEAD     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SWEEP_UP       = 2'd2;

   localparam logic [DISK_BITS-1:0] DISK_CYLINDERS_RESET = 17'd65536;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FIND,
      ST_SWEEP1,
      ST_EDGE,
      ST_SWEEP2
   } state_type;

   typedef enum logic [1:0] {
      EMIT_ASC,
      EMIT_DESC,
      EMIT_EDGE
   } emit_kind_type;

   typedef struct packed {
      logic          ins;
      logic          scan_init;
      logic          scan_step;
      logic          save_split;
      logic          emit;
      emit_kind_type emit_kind;
      logic          emit_last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic ptr_at_count;
      logic ptr_zero;
      logic find_lt;
      logic asc_final;
      logic desc_final;
      logic split_zero;
      logic split_at_count;
      logic out_free;
      logic sweep_up;
   } dp_status_type;

endpackage

>>> rtl/scan_disk_scheduler.sv
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   req_cylinder, req_batch_last
// rsp       out        rsp_valid/rsp_ready   visit, distance, total, edge, order, ovf, last
// csr       in         csr_wen               csr_index, csr_wdata
//
// A request is stored by a sorted insert, so a batch loads at one item per cycle.
// The final item then starts a split search and, after an idle step at the end of the first
// sweep, n+1 results leave at one per cycle while rsp_ready holds.
// Results leave through a single output register; a stall holds the sequencer.
// Reset is synchronous; the request store is not cleared, only its count.
module scan_disk_scheduler #(
   parameter int MAX_REQUESTS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wen,
   input  logic [sds_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [sds_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [sds_pkg::CYL_BITS-1:0]          req_cylinder,
   input  logic                                  req_batch_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [sds_pkg::CYL_BITS-1:0]          rsp_visit_cylinder,
   output logic [sds_pkg::CYL_BITS-1:0]          rsp_seek_distance,
   output logic [sds_pkg::TOTAL_BITS-1:0]        rsp_running_total,
   output logic                                  rsp_end_sweep,
   output logic [sds_pkg::ORDER_BITS-1:0]        rsp_service_order,
   output logic                                  rsp_overflowed,
   output logic                                  rsp_result_last
);

   sds_pkg::ctrl_cmd_type  cmd;
   sds_pkg::dp_status_type status;

   sds_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_batch_last (req_batch_last),
      .req_ready      (req_ready),
      .status         (status),
      .cmd            (cmd)
   );

   sds_datapath #(
      .MAX_REQUESTS (MAX_REQUESTS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wen            (csr_wen),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_cylinder       (req_cylinder),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_visit_cylinder (rsp_visit_cylinder),
      .rsp_seek_distance  (rsp_seek_distance),
      .rsp_running_total  (rsp_running_total),
      .rsp_end_sweep      (rsp_end_sweep),
      .rsp_service_order  (rsp_service_order),
      .rsp_overflowed     (rsp_overflowed),
      .rsp_result_last    (rsp_result_last),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

>>> rtl/sds_ctrl.sv
module sds_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_batch_last,
   output logic                  req_ready,
   input  sds_pkg::dp_status_type status,
   output sds_pkg::ctrl_cmd_type  cmd
);

   sds_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sds_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sds_pkg::ST_LOAD: begin
            if (req_valid && req_batch_last) state_in = sds_pkg::ST_FIND;
         end
         sds_pkg::ST_FIND: begin
            if (status.ptr_at_count || !status.find_lt) state_in = sds_pkg::ST_SWEEP1;
         end
         sds_pkg::ST_SWEEP1: begin
            if (status.sweep_up ? status.ptr_at_count : status.ptr_zero) begin
               state_in = sds_pkg::ST_EDGE;
            end
         end
         sds_pkg::ST_EDGE: begin
            if (status.out_free) begin
               if (status.sweep_up ? status.split_zero : status.split_at_count) begin
                  state_in = sds_pkg::ST_LOAD;
               end else begin
                  state_in = sds_pkg::ST_SWEEP2;
               end
            end
         end
         sds_pkg::ST_SWEEP2: begin
            if (status.out_free &&
                (status.sweep_up ? status.desc_final : status.asc_final)) begin
               state_in = sds_pkg::ST_LOAD;
            end
         end
         default: state_in = sds_pkg::ST_LOAD;
      endcase
   end

   // outputs
   always_comb begin
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.emit_kind  = sds_pkg::EMIT_ASC;
      case (state_ff)
         sds_pkg::ST_LOAD: begin
            req_ready     = 1'b1;
            cmd.ins       = req_valid;
            cmd.scan_init = req_valid && req_batch_last;
         end
         sds_pkg::ST_FIND: begin
            if (!status.ptr_at_count && status.find_lt) begin
               cmd.scan_step = 1'b1;
            end else begin
               cmd.save_split = 1'b1;
            end
         end
         sds_pkg::ST_SWEEP1: begin
            if (status.sweep_up) begin
               cmd.emit_kind = sds_pkg::EMIT_ASC;
               cmd.emit      = !status.ptr_at_count && status.out_free;
            end else begin
               cmd.emit_kind = sds_pkg::EMIT_DESC;
               cmd.emit      = !status.ptr_zero && status.out_free;
            end
         end
         sds_pkg::ST_EDGE: begin
            cmd.emit_kind = sds_pkg::EMIT_EDGE;
            cmd.emit      = status.out_free;
            cmd.emit_last = status.sweep_up ? status.split_zero : status.split_at_count;
         end
         sds_pkg::ST_SWEEP2: begin
            cmd.emit = status.out_free;
            if (status.sweep_up) begin
               cmd.emit_kind = sds_pkg::EMIT_DESC;
               cmd.emit_last = status.desc_final;
            end else begin
               cmd.emit_kind = sds_pkg::EMIT_ASC;
               cmd.emit_last = status.asc_final;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

>>> rtl/sds_datapath.sv
module sds_datapath #(
   parameter int MAX_REQUESTS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wen,
   input  logic [sds_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [sds_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  logic [sds_pkg::CYL_BITS-1:0]          req_cylinder,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [sds_pkg::CYL_BITS-1:0]          rsp_visit_cylinder,
   output logic [sds_pkg::CYL_BITS-1:0]          rsp_seek_distance,
   output logic [sds_pkg::TOTAL_BITS-1:0]        rsp_running_total,
   output logic                                  rsp_end_sweep,
   output logic [sds_pkg::ORDER_BITS-1:0]        rsp_service_order,
   output logic                                  rsp_overflowed,
   output logic                                  rsp_result_last,
   input  sds_pkg::ctrl_cmd_type                  cmd,
   output sds_pkg::dp_status_type                 status
);

   localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
   localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);
   localparam int CB = sds_pkg::CYL_BITS;
   localparam int TB = sds_pkg::TOTAL_BITS;

   logic [sds_pkg::DISK_BITS-1:0] disk_cyl_ff;
   logic [CB-1:0]                 start_ff;
   logic                          sweep_up_ff;

   logic [CB-1:0]    store_ff [MAX_REQUESTS];
   logic [CB-1:0]    store_in [MAX_REQUESTS];
   logic [MAX_REQUESTS-1:0] gt;
   logic [CNT_W-1:0] count_ff, ptr_ff, split_ff;
   logic             ovf_ff;
   logic [CB-1:0]    head_ff;
   logic [TB-1:0]    total_ff;
   logic [sds_pkg::ORDER_BITS-1:0] order_ff;
   logic             full;

   logic [CNT_W-1:0] rd_ptr;
   logic [CB-1:0]    rd_data;
   logic [CB-1:0]    edge_cyl;
   logic [CB-1:0]    emit_cyl;
   logic [CB-1:0]    emit_dist;
   logic [TB:0]      sum;
   logic [TB-1:0]    total_next;
   logic             out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         disk_cyl_ff <= sds_pkg::DISK_CYLINDERS_RESET;
         start_ff    <= '0;
         sweep_up_ff <= 1'b1;
      end else if (csr_wen) begin
         case (csr_index)
            sds_pkg::CSR_DISK_CYLINDERS: disk_cyl_ff <= csr_wdata;
            sds_pkg::CSR_START_HEAD:     start_ff    <= csr_wdata[CB-1:0];
            sds_pkg::CSR_SWEEP_UP:       sweep_up_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign full = (count_ff == CNT_MAX);

   // sorted insertion: each cell takes its left neighbor, the new value, or keeps
   always_comb begin
      for (int i = 0; i < MAX_REQUESTS; i++) begin
         gt[i] = (CNT_W'(i) < count_ff) && (store_ff[i] > req_cylinder);
      end
      for (int i = 0; i < MAX_REQUESTS; i++) begin
         if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            store_in[i] = store_ff[(i > 0) ? i - 1 : 0];
         end else if (gt[i] || (CNT_W'(i) == count_ff)) begin
            store_in[i] = req_cylinder;
         end else begin
            store_in[i] = store_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins && !full) begin
         for (int i = 0; i < MAX_REQUESTS; i++) begin
            store_ff[i] <= store_in[i];
         end
      end
   end

   assign rd_ptr  = (cmd.emit_kind == sds_pkg::EMIT_DESC) ? ptr_ff - CNT_W'(1) : ptr_ff;
   assign rd_data = store_ff[rd_ptr[IDX_W-1:0]];

   always_comb begin
      if (disk_cyl_ff == '0) begin
         edge_cyl = '0;
      end else if (disk_cyl_ff[sds_pkg::DISK_BITS-1]) begin
         edge_cyl = '1;
      end else begin
         edge_cyl = disk_cyl_ff[CB-1:0] - CB'(1);
      end
   end

   always_comb begin
      if (cmd.emit_kind == sds_pkg::EMIT_EDGE) begin
         emit_cyl = sweep_up_ff ? edge_cyl : '0;
      end else begin
         emit_cyl = rd_data;
      end
      emit_dist  = (emit_cyl >= head_ff) ? emit_cyl - head_ff : head_ff - emit_cyl;
      sum        = {1'b0, total_ff} + (TB + 1)'(emit_dist);
      total_next = sum[TB] ? '1 : sum[TB-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         ptr_ff   <= '0;
         split_ff <= '0;
         head_ff  <= '0;
         total_ff <= '0;
         order_ff <= '0;
      end else begin
         if (cmd.ins) begin
            if (full) ovf_ff <= 1'b1;
            else count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.scan_init) begin
            ptr_ff   <= '0;
            head_ff  <= start_ff;
            total_ff <= '0;
            order_ff <= '0;
         end
         if (cmd.scan_step) ptr_ff <= ptr_ff + CNT_W'(1);
         if (cmd.save_split) split_ff <= ptr_ff;
         if (cmd.emit) begin
            head_ff  <= emit_cyl;
            total_ff <= total_next;
            case (cmd.emit_kind)
               sds_pkg::EMIT_ASC: begin
                  ptr_ff   <= ptr_ff + CNT_W'(1);
                  order_ff <= order_ff + 1'b1;
               end
               sds_pkg::EMIT_DESC: begin
                  ptr_ff   <= ptr_ff - CNT_W'(1);
                  order_ff <= order_ff + 1'b1;
               end
               sds_pkg::EMIT_EDGE: ptr_ff <= split_ff;
               default: ;
            endcase
            if (cmd.emit_last) begin
               count_ff <= '0;
               ovf_ff   <= 1'b0;
               total_ff <= '0;
            end
         end
      end
   end

   // result register
   assign out_free = !rsp_valid || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_visit_cylinder <= emit_cyl;
         rsp_seek_distance  <= emit_dist;
         rsp_running_total  <= total_next;
         rsp_end_sweep      <= (cmd.emit_kind == sds_pkg::EMIT_EDGE);
         rsp_service_order  <= (cmd.emit_kind == sds_pkg::EMIT_EDGE) ? '0 :
                               order_ff + 1'b1;
         rsp_overflowed     <= ovf_ff;
         rsp_result_last    <= cmd.emit_last;
      end
   end

   always_comb begin
      status.ptr_at_count   = (ptr_ff == count_ff);
      status.ptr_zero       = (ptr_ff == '0);
      status.find_lt        = (rd_data < start_ff);
      status.asc_final      = ((ptr_ff + CNT_W'(1)) == count_ff);
      status.desc_final     = (ptr_ff == CNT_W'(1));
      status.split_zero     = (split_ff == '0);
      status.split_at_count = (split_ff == count_ff);
      status.out_free       = out_free;
      status.sweep_up       = sweep_up_ff;
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result issued while output register occupied");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("request count above capacity");

   a_batch_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && cmd.emit_last |=> count_ff == '0 && !ovf_ff && rsp_result_last)
      else $error("batch state not cleared after final result");

   a_no_ins_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !cmd.ins)
      else $error("request stored during emission");

endmodule

>>> dv/scan_order_checker.sv
module scan_order_checker
   import sds_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wen,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [CYL_BITS-1:0]       req_cylinder,
   input  logic                      req_batch_last,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [CYL_BITS-1:0]       rsp_visit_cylinder,
   input  logic [CYL_BITS-1:0]       rsp_seek_distance,
   input  logic [TOTAL_BITS-1:0]     rsp_running_total,
   input  logic                      rsp_end_sweep,
   input  logic [ORDER_BITS-1:0]     rsp_service_order,
   input  logic                      rsp_overflowed,
   input  logic                      rsp_result_last,
   output int                        fail_count,
   output int                        moves_pending,
   output int                        moves_checked,
   output int                        batches_done
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = 32;
   localparam int TOTAL_MAX   = (1 << TOTAL_BITS) - 1;
   localparam int DISK_MAX    = 1 << CYL_BITS;

   typedef struct packed {
      logic [CYL_BITS-1:0]   visit;
      logic [CYL_BITS-1:0]   seek;
      logic [TOTAL_BITS-1:0] total;
      logic                  at_edge;
      logic [ORDER_BITS-1:0] order;
      logic                  ovf;
      logic                  last;
   } head_move_type;

   logic [CYL_BITS-1:0]  sorted_reqs [STORE_DEPTH];
   int                   req_total;
   logic                 dropped;
   logic [DISK_BITS-1:0] disk_size_reg;
   logic [CYL_BITS-1:0]  start_reg;
   logic                 up_reg;
   logic [CYL_BITS-1:0]  head_cyl;
   int                   seek_sum;
   head_move_type        moves_due [$];

   task automatic add_move(input logic [CYL_BITS-1:0] cyl, input logic at_edge,
                           input int order, input logic is_final);
      head_move_type m;
      logic [CYL_BITS-1:0] step_dist;
      step_dist = (cyl >= head_cyl) ? cyl - head_cyl : head_cyl - cyl;
      seek_sum = seek_sum + step_dist;
      if (seek_sum > TOTAL_MAX) seek_sum = TOTAL_MAX;
      head_cyl  = cyl;
      m.visit   = cyl;
      m.seek    = step_dist;
      m.total   = seek_sum[TOTAL_BITS-1:0];
      m.at_edge = at_edge;
      m.order   = order[ORDER_BITS-1:0];
      m.ovf     = dropped;
      m.last    = is_final;
      moves_due.push_back(m);
   endtask

   // sorted insert; the batch's final item builds the whole elevator order
   task automatic store_request(input logic [CYL_BITS-1:0] cyl, input logic last);
      int j;
      int split;
      int order;
      int size;
      logic [CYL_BITS-1:0] edge_cyl;
      if (req_total < STORE_DEPTH) begin
         j = req_total;
         while (j > 0 && sorted_reqs[j-1] > cyl) begin
            sorted_reqs[j] = sorted_reqs[j-1];
            j--;
         end
         sorted_reqs[j] = cyl;
         req_total++;
      end else begin
         dropped = 1'b1;
      end
      if (!last) return;

      size = int'(disk_size_reg);
      if (size == 0) size = 1;
      if (size > DISK_MAX) size = DISK_MAX;
      edge_cyl = CYL_BITS'(size - 1);
      head_cyl = start_reg;
      seek_sum = 0;
      split = 0;
      while (split < req_total && sorted_reqs[split] < start_reg) split++;
      order = 0;

      if (up_reg) begin
         for (j = split; j < req_total; j++) begin
            order++;
            add_move(sorted_reqs[j], 1'b0, order, 1'b0);
         end
         add_move(edge_cyl, 1'b1, 0, split == 0);
         for (j = split; j > 0; j--) begin
            order++;
            add_move(sorted_reqs[j-1], 1'b0, order, j == 1);
         end
      end else begin
         for (j = split; j > 0; j--) begin
            order++;
            add_move(sorted_reqs[j-1], 1'b0, order, 1'b0);
         end
         add_move('0, 1'b1, 0, split == req_total);
         for (j = split; j < req_total; j++) begin
            order++;
            add_move(sorted_reqs[j], 1'b0, order, j == req_total - 1);
         end
      end
      req_total = 0;
      dropped   = 1'b0;
      batches_done++;
   endtask

   task automatic compare_field(input string field, input longint unsigned want,
                                input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      head_move_type m;
      if (reset) begin
         req_total     = 0;
         dropped       = 1'b0;
         head_cyl      = '0;
         seek_sum      = 0;
         disk_size_reg = DISK_CYLINDERS_RESET;
         start_reg     = '0;
         up_reg        = 1'b1;
         fail_count    = 0;
         moves_checked = 0;
         batches_done  = 0;
         moves_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (moves_due.size() == 0) begin
               $error("unexpected result: visit_cylinder %0d", rsp_visit_cylinder);
               fail_count++;
            end else begin
               m = moves_due.pop_front();
               compare_field("visit_cylinder", m.visit, rsp_visit_cylinder);
               compare_field("seek_distance", m.seek, rsp_seek_distance);
               compare_field("running_total", m.total, rsp_running_total);
               compare_field("end_sweep", m.at_edge, rsp_end_sweep);
               compare_field("service_order", m.order, rsp_service_order);
               compare_field("overflowed", m.ovf, rsp_overflowed);
               compare_field("result_last", m.last, rsp_result_last);
               moves_checked++;
            end
         end
         if (csr_wen) begin
            case (csr_index)
               CSR_DISK_CYLINDERS: disk_size_reg = csr_wdata[DISK_BITS-1:0];
               CSR_START_HEAD:     start_reg     = csr_wdata[CYL_BITS-1:0];
               CSR_SWEEP_UP:       up_reg        = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) store_request(req_cylinder, req_batch_last);
      end
      moves_pending = moves_due.size();
   end

endmodule

>>> dv/tb_scan_disk_scheduler.sv
module tb_scan_disk_scheduler;
   timeunit 1ns;
   timeprecision 1ps;
   import sds_pkg::*;

   localparam int STALL_MAX     = 12;
   localparam int RANDOM_ITEMS  = 350;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 300000;

   logic                      clock          = 1'b0;
   logic                      reset          = 1'b1;
   logic                      csr_wen        = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index      = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata      = '0;
   logic                      req_valid      = 1'b0;
   logic                      req_ready;
   logic [CYL_BITS-1:0]       req_cylinder   = '0;
   logic                      req_batch_last = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready      = 1'b0;
   logic [CYL_BITS-1:0]       rsp_visit_cylinder;
   logic [CYL_BITS-1:0]       rsp_seek_distance;
   logic [TOTAL_BITS-1:0]     rsp_running_total;
   logic                      rsp_end_sweep;
   logic [ORDER_BITS-1:0]     rsp_service_order;
   logic                      rsp_overflowed;
   logic                      rsp_result_last;

   int fail_count;
   int moves_pending;
   int moves_checked;
   int batches_done;

   int cycle_count  = 0;
   int items_sent   = 0;
   int full_batches = 0;
   bit req_steady   = 1'b0;
   bit rsp_steady   = 1'b0;

   logic [DISK_BITS-1:0] cur_disk  = DISK_CYLINDERS_RESET;
   logic [CYL_BITS-1:0]  cur_start = '0;
   logic [CYL_BITS-1:0]  last_cyl  = '0;

   scan_disk_scheduler dut (.*);

   scan_order_checker order_check (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** scan_disk_scheduler: FAILED **");
         $finish;
      end
   end

   function automatic int draw_gap(bit steady);
      return steady ? 0 : $urandom_range(0, STALL_MAX);
   endfunction

   // result side: random stall before each item, with occasional no-stall stretches
   initial begin
      int stall;
      @(posedge clock);
      forever begin
         stall = draw_gap(rsp_steady);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(negedge clock); while (!rsp_valid);
         @(posedge clock);
         if ($urandom_range(0, 15) == 0) rsp_steady = !rsp_steady;
      end
   end

   // every task below starts and ends at a rising edge
   task automatic send_request(input logic [CYL_BITS-1:0] cyl, input logic last);
      int gap;
      gap = draw_gap(req_steady);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cylinder   <= cyl;
      req_batch_last <= last;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      last_cyl = cyl;
      items_sent++;
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (moves_pending != 0);
      @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [DISK_BITS-1:0] disk,
                             input logic [CYL_BITS-1:0] start, input logic up);
      csr_write(CSR_DISK_CYLINDERS, disk);
      csr_write(CSR_START_HEAD, CSR_DATA_BITS'(start));
      csr_write(CSR_SWEEP_UP, CSR_DATA_BITS'(up));
      csr_wen   <= 1'b0;
      cur_disk  = disk;
      cur_start = start;
   endtask

   function automatic logic [CYL_BITS-1:0] pick_cylinder();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return last_cyl;
         3, 4:    return cur_start + CYL_BITS'($urandom_range(0, 64)) - CYL_BITS'(32);
         5:       return CYL_BITS'(cur_disk - DISK_BITS'($urandom_range(0, 8)));
         default: return CYL_BITS'($urandom);
      endcase
   endfunction

   task automatic send_batch(input int size);
      if (size > 32) full_batches++;
      req_steady = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < size; i++) send_request(pick_cylinder(), i == size - 1);
   endtask

   initial begin
      int random_start;
      logic [DISK_BITS-1:0] disk;
      logic [CYL_BITS-1:0] start;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: full disk, head at 0, sweeping up
      send_request(16'd0, 1'b1);
      wait_drain();
      send_request(16'hFFFF, 1'b0);
      send_request(16'd0, 1'b0);
      send_request(16'd100, 1'b0);
      send_request(16'd100, 1'b1);
      wait_drain();

      // zero-size disk, sweeping down from the top; all requests beyond the edge
      set_config(17'd0, 16'hFFFF, 1'b0);
      send_request(16'hFFFF, 1'b0);
      send_request(16'd40000, 1'b0);
      send_request(16'hFFFF, 1'b1);
      wait_drain();

      // oversize disk saturates to full range
      set_config(17'h1FFFF, 16'h8000, 1'b1);
      send_request(16'h7FFF, 1'b0);
      send_request(16'h8000, 1'b0);
      send_request(16'hFFFF, 1'b0);
      send_request(16'h0001, 1'b1);
      wait_drain();

      // one-cylinder disk: edge move goes downward
      set_config(17'd1, 16'd5, 1'b1);
      send_request(16'd10, 1'b0);
      send_request(16'd3, 1'b0);
      send_request(16'd5, 1'b1);
      wait_drain();

      // nothing below the start while sweeping down
      set_config(17'd65536, 16'd300, 1'b0);
      send_request(16'd400, 1'b0);
      send_request(16'd500, 1'b1);
      wait_drain();

      // nothing at or above the start while sweeping up
      set_config(17'd1000, 16'hFFFF, 1'b1);
      send_request(16'd10, 1'b0);
      send_request(16'd20, 1'b1);
      wait_drain();

      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0:       disk = '0;
            1:       disk = 17'd1;
            2:       disk = 17'd65536;
            3:       disk = '1;
            4:       disk = DISK_BITS'($urandom_range(2, 4096));
            default: disk = DISK_BITS'($urandom_range(1, 131071));
         endcase
         case ($urandom_range(0, 4))
            0:       start = '0;
            1:       start = '1;
            2:       start = CYL_BITS'($urandom_range(0, 4096));
            default: start = CYL_BITS'($urandom);
         endcase
         set_config(disk, start, 1'($urandom_range(0, 1)));
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 9) == 0) send_batch($urandom_range(30, 40));
            else send_batch($urandom_range(1, 8));
         end
         wait_drain();
      end

      $display("checked %0d head moves over %0d batches from %0d requests",
               moves_checked, batches_done, items_sent);
      $display("%0d batches overran the store; zero, one, full and oversize disks in both "
               , full_batches, "sweep directions");
      if (fail_count == 0) begin
         $display("** scan_disk_scheduler: PASSED **");
      end else begin
         $display("** scan_disk_scheduler: FAILED **");
      end
      $finish;
   end

endmodule
